// ===== rtl/stereo_pcm_gain_saturate_macros.svh =====
// ----------------------------------------------------------------------------
// stereo_pcm_gain_saturate assertion macros
// Shared property wrappers; all checks use clk and rst_n of the module.
// ----------------------------------------------------------------------------
`ifndef STEREO_PCM_GAIN_SATURATE_MACROS_SVH
`define STEREO_PCM_GAIN_SATURATE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SPGS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spgs check failed");

// next-cycle implication
`define SPGS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spgs check failed");

`else

`define SPGS_ASSERT_IMP(lbl, ante, cons)
`define SPGS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/spgs_pkg.sv =====
// ----------------------------------------------------------------------------
// spgs_pkg
// Types and constants of the stereo PCM gain/saturate block.
// ----------------------------------------------------------------------------
`default_nettype none

package spgs_pkg;

  localparam int WORD_W   = 32;
  localparam int SAMP_W   = 24;   // widest sample (24-bit mode)
  localparam int GAIN_W   = 17;   // Q4.12 signed
  localparam int FRAC_W   = 12;
  localparam int PROD_W   = SAMP_W + GAIN_W;
  localparam int SHIFT_W  = PROD_W - FRAC_W;
  localparam int CLAMP_W  = SAMP_W + 1;  // holds +/- 2^23
  localparam int NUM_FIELDS = 2;         // channels carried by the payload
  localparam int ADDR_W   = 3;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd8192;  // 2.0

  typedef enum logic [0:0] {
    REG_FORMAT = 1'b0,
    REG_GAIN   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] left_word;
    logic signed [WORD_W-1:0] right_word;
    logic                     frame_end_in;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] left_out;
    logic signed [WORD_W-1:0] right_out;
    logic                     frame_end_out;
  } out_t;

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } adv_t;

endpackage

`default_nettype wire

// ===== rtl/stereo_pcm_gain_saturate.sv =====
// ----------------------------------------------------------------------------
// stereo_pcm_gain_saturate
// Stereo PCM gain with saturation and full-scale trim, 16-bit or 24-in-32.
//
//   channel   direction  handshake                 payload
//   in_       input      in_valid / in_stall       spgs_pkg::in_t
//   out_      output     out_valid / out_stall     spgs_pkg::out_t
//   config    input      psel/penable/pwrite/...   32-bit APB registers
//
// One frame per cycle unless out_stall holds a full pipe; registered stages multiply, clamp, trim/repack.
// Stage valid bits travel with the data; a bubble is filled while stalled.
// in_stall follows out_stall combinationally only when all stages are full.
// Sync reset empties the pipe and sets format 16-bit, gain 2.0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stereo_pcm_gain_saturate_macros.svh"

module stereo_pcm_gain_saturate #(
  parameter int CHANNELS = 2
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,

  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire spgs_pkg::in_t                   in_data,

  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      spgs_pkg::out_t                  out_data,

  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [spgs_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [31:0]                     pwdata,
  output      logic [31:0]                     prdata,
  output      logic                            pready
);

  logic                              fmt_r, fmt_nxt;
  logic signed [spgs_pkg::GAIN_W-1:0] gain_r, gain_nxt;
  logic                              cfg_wr;
  spgs_pkg::reg_idx_t                reg_idx;

  logic v1_r, v2_r, v3_r;
  logic fe1_r, fe2_r, fe3_r;
  spgs_pkg::adv_t adv;

  logic [spgs_pkg::WORD_W-1:0] lane_in  [spgs_pkg::NUM_FIELDS];
  logic [spgs_pkg::WORD_W-1:0] lane_out [spgs_pkg::NUM_FIELDS];

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = spgs_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    fmt_nxt  = fmt_r;
    gain_nxt = gain_r;
    if (cfg_wr) begin
      case (reg_idx)
        spgs_pkg::REG_FORMAT: fmt_nxt  = pwdata[0];
        spgs_pkg::REG_GAIN:   gain_nxt = pwdata[spgs_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      spgs_pkg::REG_FORMAT: prdata = {31'b0, fmt_r};
      spgs_pkg::REG_GAIN:   prdata = {{(32-spgs_pkg::GAIN_W){1'b0}}, gain_r};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r  <= 1'b0;
      gain_r <= spgs_pkg::GAIN_RESET;
    end else begin
      fmt_r  <= fmt_nxt;
      gain_r <= gain_nxt;
    end
  end

  // pipeline control: a stage loads when empty or when the next one moves
  assign adv.s3   = !v3_r || !out_stall;
  assign adv.s2   = !v2_r || adv.s3;
  assign adv.s1   = !v1_r || adv.s2;
  assign in_stall = !adv.s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv.s1) v1_r <= in_valid;
      if (adv.s2) v2_r <= v1_r;
      if (adv.s3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) fe1_r <= in_data.frame_end_in;
    if (adv.s2) fe2_r <= fe1_r;
    if (adv.s3) fe3_r <= fe2_r;
  end

  assign lane_in[0] = in_data.left_word;
  assign lane_in[1] = in_data.right_word;

  for (genvar c = 0; c < spgs_pkg::NUM_FIELDS; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      spgs_lane u_lane (
        .clk      (clk),
        .adv      (adv),
        .wide     (fmt_r),
        .gain     (gain_r),
        .word     (lane_in[c]),
        .word_out (lane_out[c])
      );
    end else begin : g_off
      assign lane_out[c] = '0;
    end
  end

  assign out_valid              = v3_r;
  assign out_data.left_out      = lane_out[0];
  assign out_data.right_out     = lane_out[1];
  assign out_data.frame_end_out = fe3_r;

  `SPGS_ASSERT_IMP(a_free_out_no_stall, !out_stall, !in_stall)
  `SPGS_ASSERT_NXT(a_accept_fills_s1, in_valid && !in_stall, v1_r)
  `SPGS_ASSERT_NXT(a_s2_moves_to_s3, v2_r && adv.s3, v3_r)
  `SPGS_ASSERT_IMP(a_full_pipe_stalls, v1_r && v2_r && v3_r && out_stall, in_stall)

endmodule

`default_nettype wire

// ===== rtl/spgs_lane.sv =====
// ----------------------------------------------------------------------------
// spgs_lane
// One channel datapath: multiply, shift and clamp, trim and repack.
// ----------------------------------------------------------------------------
`default_nettype none

module spgs_lane (
  input  wire logic                                  clk,
  input  wire spgs_pkg::adv_t                        adv,
  input  wire logic                                  wide,
  input  wire logic signed [spgs_pkg::GAIN_W-1:0]    gain,
  input  wire logic        [spgs_pkg::WORD_W-1:0]    word,
  output      logic        [spgs_pkg::WORD_W-1:0]    word_out
);

  localparam logic signed [spgs_pkg::SHIFT_W-1:0] FULL_HI = spgs_pkg::SHIFT_W'(1 << 23);
  localparam logic signed [spgs_pkg::SHIFT_W-1:0] FULL_LO = spgs_pkg::SHIFT_W'(1 << 15);

  logic signed [spgs_pkg::SAMP_W-1:0]  samp;
  logic signed [spgs_pkg::PROD_W-1:0]  prod_nxt, prod_r;
  logic signed [spgs_pkg::SHIFT_W-1:0] shifted, full, full_neg;
  logic signed [spgs_pkg::CLAMP_W-1:0] p_nxt, p_r;
  logic signed [spgs_pkg::CLAMP_W-1:0] y;
  logic        [spgs_pkg::WORD_W-1:0]  word_nxt, word_r;

  // stage 1: sample extract and multiply
  always_comb begin
    if (wide) begin
      samp = word[31:8];
    end else begin
      samp = {{8{word[15]}}, word[15:0]};
    end
    prod_nxt = spgs_pkg::PROD_W'(samp) * spgs_pkg::PROD_W'(gain);
  end

  // stage 2: floor shift by 12 and clamp to +/- full scale
  always_comb begin
    shifted  = prod_r[spgs_pkg::PROD_W-1:spgs_pkg::FRAC_W];
    full     = wide ? FULL_HI : FULL_LO;
    full_neg = -full;
    if (shifted > full) begin
      p_nxt = full[spgs_pkg::CLAMP_W-1:0];
    end else if (shifted < full_neg) begin
      p_nxt = full_neg[spgs_pkg::CLAMP_W-1:0];
    end else begin
      p_nxt = shifted[spgs_pkg::CLAMP_W-1:0];
    end
  end

  // stage 3: p*(F-1)/F toward zero is p moved one step toward zero
  always_comb begin
    if (p_r > 0) begin
      y = p_r - spgs_pkg::CLAMP_W'(1);
    end else if (p_r < 0) begin
      y = p_r + spgs_pkg::CLAMP_W'(1);
    end else begin
      y = '0;
    end
    if (wide) begin
      word_nxt = {y[23:0], 8'h00};
    end else begin
      word_nxt = {{16{y[15]}}, y[15:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      prod_r <= prod_nxt;
    end
    if (adv.s2) begin
      p_r <= p_nxt;
    end
    if (adv.s3) begin
      word_r <= word_nxt;
    end
  end

  assign word_out = word_r;

endmodule

`default_nettype wire
